// ===== design/tgbc_pkg.sv =====
// Shared types and constants for the tile grid box collision block.
// No dependencies; the tile unit, sequencer and top-level design files import this package.
`default_nettype none

package tgbc_pkg;

   localparam int ROW_BITS  = 32;  // wall bits held per map row
   localparam int ROW_IDX_W = 4;
   localparam int TILE_W    = 8;
   localparam int SIZE_W    = 12;
   localparam int POS_W     = 16;
   localparam int CW        = 20;  // internal coordinate width, holds box and tile edges

   localparam logic [TILE_W-1:0] TILE_SIZE_RESET = 8'd32;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_CHECK = 2'd1,
      OP_RES_X = 2'd2,
      OP_RES_Y = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type                   operation;
      logic [ROW_IDX_W-1:0]     row_index;
      logic [ROW_BITS-1:0]      row_bits;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [SIZE_W-1:0]        rect_width;
      logic [SIZE_W-1:0]        rect_height;
      logic signed [POS_W-1:0]  move_amount;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [POS_W-1:0]  new_x;
      logic signed [POS_W-1:0]  new_y;
   } rsp_type;

   // sequencer to tile unit
   typedef struct packed {
      logic      load;    // latch the accepted item
      logic      step;    // one tile is tested this cycle
      logic      wall;    // that tile is a wall
      coord_type tile_x;
      coord_type tile_y;
   } scan_ctrl_type;

endpackage

`default_nettype wire

// ===== design/tgbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds until the next read. No dependencies.
`default_nettype none

module tgbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/tgbc_tile_unit.sv =====
// Box register and per-tile overlap test with push-out for one tile a cycle.
// Depends on tgbc_pkg.
`default_nettype none

module tgbc_tile_unit
   import tgbc_pkg::*;
(
   input  wire logic                 clock,
   input  wire scan_ctrl_type        ctrl,
   input  wire req_type              req_data,
   input  wire logic [TILE_W-1:0]    tile_size,
   output rsp_type                   result
);

   coord_type         x_ff, y_ff;
   logic [SIZE_W-1:0] w_ff, h_ff;
   op_type            op_ff;
   logic              neg_ff;
   logic              hit_ff;

   coord_type ts, w_c, h_c;
   coord_type tile_x_far, tile_y_far;
   logic      overlap;

   always_comb begin
      ts         = coord_type'({{(CW-TILE_W){1'b0}}, tile_size});
      w_c        = coord_type'({{(CW-SIZE_W){1'b0}}, w_ff});
      h_c        = coord_type'({{(CW-SIZE_W){1'b0}}, h_ff});
      tile_x_far = ctrl.tile_x + ts;
      tile_y_far = ctrl.tile_y + ts;
      // positive-area overlap; empty box or empty tile never overlaps
      overlap = ctrl.wall && (tile_size != '0) && (w_ff != '0) && (h_ff != '0) &&
                (x_ff < tile_x_far) && (ctrl.tile_x < x_ff + w_c) &&
                (y_ff < tile_y_far) && (ctrl.tile_y < y_ff + h_c);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff   <= coord_type'(req_data.pos_x);
         y_ff   <= coord_type'(req_data.pos_y);
         w_ff   <= req_data.rect_width;
         h_ff   <= req_data.rect_height;
         op_ff  <= req_data.operation;
         neg_ff <= req_data.move_amount[POS_W-1];
         hit_ff <= 1'b0;
      end else if (ctrl.step && overlap) begin
         hit_ff <= 1'b1;
         // push against the tile; later tiles see the moved box
         if (op_ff == OP_RES_X) begin
            x_ff <= neg_ff ? tile_x_far : ctrl.tile_x - w_c;
         end
         if (op_ff == OP_RES_Y) begin
            y_ff <= neg_ff ? tile_y_far : ctrl.tile_y - h_c;
         end
      end
   end

   assign result.hit   = hit_ff;
   assign result.new_x = x_ff[POS_W-1:0];
   assign result.new_y = y_ff[POS_W-1:0];

endmodule

`default_nettype wire

// ===== design/tgbc_seq.sv =====
// Sequencer: item intake, map row fetch, row-major tile walk and result hand-off.
// Depends on tgbc_pkg; drives the wall map RAM ports.
`default_nettype none

module tgbc_seq
   import tgbc_pkg::*;
#(
   parameter int MAP_ROWS = 16,
   parameter int MAP_COLS = 32,
   localparam int RAW     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire req_type              req_data,
   output logic                      req_ready,
   input  wire logic                 out_busy,
   input  wire logic [TILE_W-1:0]    tile_size,
   input  wire logic [ROW_BITS-1:0]  rd_data,
   output logic                      rd_en,
   output logic [RAW-1:0]            rd_addr,
   output logic                      wr_en,
   output logic [RAW-1:0]            wr_addr,
   output logic                      finish,
   output scan_ctrl_type             ctrl
);

   // columns past the stored row word are never walls
   localparam int NC    = (MAP_COLS < ROW_BITS) ? MAP_COLS : ROW_BITS;
   localparam int COL_W = (NC > 1) ? $clog2(NC) : 1;
   localparam int BIT_W = $clog2(ROW_BITS);
   localparam int ROW_CMP_W = 7;

   state_type         state_ff, state_in;
   logic [RAW-1:0]    row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   coord_type         tx_ff, tx_in, ty_ff, ty_in;
   logic [MAP_ROWS-1:0] valid_ff;
   logic              row_valid_ff;

   logic      accept, last_col, last_row, row_in_range, scan_needed;
   coord_type ts;

   assign accept       = req_valid && req_ready;
   assign last_col     = (col_ff == COL_W'(NC - 1));
   assign last_row     = (row_ff == RAW'(MAP_ROWS - 1));
   assign row_in_range = ({{(ROW_CMP_W-ROW_IDX_W){1'b0}}, req_data.row_index} <
                          ROW_CMP_W'(MAP_ROWS));
   assign scan_needed  = (req_data.operation == OP_CHECK) ||
                         (req_data.move_amount != '0);
   assign ts           = coord_type'({{(CW-TILE_W){1'b0}}, tile_size});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation != OP_WRITE && scan_needed) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FETCH:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (last_col && last_row) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      finish      = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.step   = 1'b0;
      ctrl.wall   = row_valid_ff && rd_data[BIT_W'(col_ff)];
      ctrl.tile_x = tx_ff;
      ctrl.tile_y = ty_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = accept;
            wr_en     = accept && (req_data.operation == OP_WRITE) && row_in_range;
         end
         ST_FETCH: begin
            rd_en = 1'b1;
         end
         ST_SCAN: begin
            ctrl.step = 1'b1;
            // prefetch the next row during the last column
            if (last_col && !last_row) begin
               rd_en   = 1'b1;
               rd_addr = RAW'(row_ff + 1'b1);
            end
         end
         ST_FINISH: begin
            finish = !out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign wr_addr     = RAW'(req_data.row_index);

   // walk counters and tile origin accumulators
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      tx_in  = tx_ff;
      ty_in  = ty_ff;
      if (state_ff == ST_FETCH) begin
         row_in = '0;
         col_in = '0;
         tx_in  = '0;
         ty_in  = '0;
      end else if (state_ff == ST_SCAN) begin
         if (last_col) begin
            col_in = '0;
            tx_in  = '0;
            row_in = RAW'(row_ff + 1'b1);
            ty_in  = ty_ff + ts;
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
            tx_in  = tx_ff + ts;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      tx_ff  <= tx_in;
      ty_ff  <= ty_in;
      // a row never written reads as empty
      if (rd_en) begin
         row_valid_ff <= valid_ff[rd_addr];
      end
   end

   a_write_on_transfer : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (accept && req_data.operation == OP_WRITE))
      else $error("map row written outside an accepted write transfer");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      finish |-> !out_busy)
      else $error("result produced while the output register is still held");

   a_prefetch_edge : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && last_col && !last_row) |=>
      (state_ff == ST_SCAN && col_ff == '0 && row_ff == $past(RAW'(row_ff + 1'b1))))
      else $error("row walk lost step with row prefetch");

endmodule

`default_nettype wire

// ===== design/tile_grid_box_collision_top.sv =====
// Axis-aligned box against tile-map collision. A wall map of MAP_ROWS rows,
// 32 bits each, lives in a RAM and starts empty after reset (per-row valid
// bits, no clearing pass). A write item skips the tile walk. A check item, and a
// resolve item with a non-zero move, walk every tile in row-major order at one
// tile per cycle, the current row held at the RAM read port while the next is
// fetched on the last column; MAP_ROWS * min(MAP_COLS, 32) tiles are walked.
// A resolve item with zero move skips the walk too.
// The result sits in an output register, so the next item is taken while it
// waits. tile_size is written over the csr port while the block is idle.
`default_nettype none

module tile_grid_box_collision_top
   import tgbc_pkg::*;
#(
   parameter int MAP_ROWS = 16,
   parameter int MAP_COLS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [TILE_W-1:0]  csr_data
);

   localparam int RAW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

   logic [TILE_W-1:0]   tile_size_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                out_busy, finish;
   logic                rd_en, wr_en;
   logic [RAW-1:0]      rd_addr, wr_addr;
   logic [ROW_BITS-1:0] rd_data;
   scan_ctrl_type       ctrl;
   rsp_type             result;

   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign csr_ready = req_ready;

   tgbc_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (MAP_ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.row_bits),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tgbc_seq #(
      .MAP_ROWS (MAP_ROWS),
      .MAP_COLS (MAP_COLS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .out_busy  (out_busy),
      .tile_size (tile_size_ff),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .finish    (finish),
      .ctrl      (ctrl)
   );

   tgbc_tile_unit u_tile (
      .clock     (clock),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .tile_size (tile_size_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff <= TILE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tile_size_ff <= csr_data;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
